FILE: rtl/psu_pkg.sv
// ---------------------------------------------------------------------------
// psu_pkg: shared types and codes for the positional array store
// Command and status codes, the per-cell control word and field widths.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package psu_pkg;

    // field widths
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 6;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    // build-time defaults
    localparam int DEF_CAPACITY = 64;
    localparam int MAX_RESULTS  = 64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // what every cell does with its entry
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_DELETE,
        CM_ROTATE
    } t_cell_mode;

    // control word broadcast along the chain
    typedef struct packed {
        t_cell_mode                mode;
        logic [POS_W-1:0]          pos;
        logic signed [DATA_W-1:0]  value;
    } t_cell_ctrl;

endpackage

FILE: rtl/psu_cell.sv
// ---------------------------------------------------------------------------
// psu_cell: one storage cell of the positional array store
// Holds one entry and takes its next value from itself, its left or right
// neighbor, or the broadcast value, as the control word and its place say.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psu_cell
    import psu_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                     i_clk,
    input  t_cell_ctrl               i_ctrl,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    output logic signed [DATA_W-1:0] o_data
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    // pick the next entry value
    always_comb begin
        n_data = r_data;
        case (i_ctrl.mode)
            CM_INSERT: begin
                if (IDX == int'(i_ctrl.pos)) begin
                    n_data = i_ctrl.value;
                end else if (IDX > int'(i_ctrl.pos)) begin
                    n_data = i_left;
                end
            end
            CM_DELETE: begin
                if (IDX >= int'(i_ctrl.pos)) begin
                    n_data = i_right;
                end
            end
            CM_ROTATE: begin
                n_data = i_right;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: rtl/positional_array_store_unit.sv
// ---------------------------------------------------------------------------
// positional_array_store_unit: ordered list of signed words in a cell chain
// Clear, insert, delete, search and dump over a row of cells that shift
// left or right together; search and dump rotate the row once around.
// ---------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | i_in_valid, o_in_ready, i_cmd,           | in
//          | i_position, i_value                      |
//  out     | o_out_valid, i_out_ready, o_status,      | out
//          | o_index, o_data, o_last                  |
//
//  clear, insert, delete and bad commands do not rotate: the whole chain
//  shifts in the cycle the word is taken, and the result is registered.
//  search and dump rotate the chain once around through cell 0;
//  a search then presents its result from S_SEND. dump rotation pauses
//  while a dumped word waits on the output; the rotation counter ends it.
//  reset clears the count and control only; entries need no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_array_store_unit
    import psu_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [INDEX_W-1:0]       o_index,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_last
);

    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int CW       = (CNT_BITS > POS_W) ? CNT_BITS : POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROTATE,
        S_SEND
    } t_state;

    t_state                   r_state;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_k;
    logic [CW-1:0]            r_n;
    logic                     r_is_dump;
    logic                     r_found;
    logic [INDEX_W-1:0]       r_hit;
    logic signed [DATA_W-1:0] r_val;
    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_status;
    logic [INDEX_W-1:0]       r_index;
    logic signed [DATA_W-1:0] r_data;
    logic                     r_last;

    logic                     w_in_acc;
    logic                     w_out_free;
    logic                     w_emit;
    logic                     w_adv;
    logic                     w_last_k;
    logic [CW-1:0]            w_pos;
    logic                     w_ins_ok;
    logic                     w_del_ok;
    logic signed [DATA_W-1:0] w_head;
    t_cell_ctrl               w_ctrl;
    logic signed [DATA_W-1:0] w_cell [CAPACITY];

    // handshake and step conditions
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_pos      = CW'(i_position);
    assign w_ins_ok   = (w_pos <= r_count) && (r_count < CW'(CAPACITY));
    assign w_del_ok   = w_pos < r_count;
    assign w_head     = w_cell[0];
    assign w_emit     = r_is_dump && (r_k < r_n);
    assign w_adv      = (r_state == S_ROTATE) && (!w_emit || w_out_free);
    assign w_last_k   = r_k == CW'(CAPACITY - 1);

    // control word for the chain
    always_comb begin
        w_ctrl.mode  = CM_HOLD;
        w_ctrl.pos   = i_position;
        w_ctrl.value = i_value;
        if (w_in_acc) begin
            case (i_cmd)
                CMD_INSERT: begin
                    if (w_ins_ok) begin
                        w_ctrl.mode = CM_INSERT;
                    end
                end
                CMD_DELETE: begin
                    if (w_del_ok) begin
                        w_ctrl.mode = CM_DELETE;
                    end
                end
                default: begin
                    w_ctrl.mode = CM_HOLD;
                end
            endcase
        end
        if (w_adv) begin
            w_ctrl.mode = CM_ROTATE;
        end
    end

    // row of cells, last one wraps to cell 0 for rotation
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_wrap
            assign w_right = w_cell[0];
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end
        psu_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell[g])
        );
    end

    // command sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_k         <= '0;
            r_is_dump   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_k         <= '0;
                        r_found     <= 1'b0;
                        r_val       <= i_value;
                        r_is_dump   <= (i_cmd == CMD_DUMP);
                        r_n         <= (r_count > CW'(MAX_RESULTS)) ?
                                       CW'(MAX_RESULTS) : r_count;
                        r_out_valid <= 1'b1;
                        r_status    <= ST_OK;
                        r_index     <= '0;
                        r_data      <= '0;
                        r_last      <= 1'b1;
                        case (i_cmd)
                            CMD_CLEAR: begin
                                r_count <= '0;
                            end
                            CMD_INSERT: begin
                                if (w_ins_ok) begin
                                    r_count <= r_count + CW'(1);
                                end else begin
                                    r_status <= ST_BAD;
                                end
                            end
                            CMD_DELETE: begin
                                if (w_del_ok) begin
                                    r_count <= r_count - CW'(1);
                                end else begin
                                    r_status <= ST_BAD;
                                end
                            end
                            CMD_SEARCH: begin
                                if (r_count == '0) begin
                                    r_status <= ST_NOT_FOUND;
                                end else begin
                                    r_out_valid <= 1'b0;
                                    r_state     <= S_ROTATE;
                                end
                            end
                            CMD_DUMP: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_out_valid <= 1'b0;
                                    r_state     <= S_ROTATE;
                                end
                            end
                            default: begin
                                r_status <= ST_BAD;
                            end
                        endcase
                    end
                end
                S_ROTATE: begin
                    if (w_adv) begin
                        r_k <= r_k + CW'(1);
                        if (w_emit) begin
                            r_out_valid <= 1'b1;
                            r_status    <= ST_OK;
                            r_index     <= r_k[INDEX_W-1:0];
                            r_data      <= w_head;
                            r_last      <= (r_k == r_n - CW'(1));
                        end
                        if (!r_is_dump && !r_found && (r_k < r_count) &&
                            (w_head == r_val)) begin
                            r_found <= 1'b1;
                            r_hit   <= r_k[INDEX_W-1:0];
                        end
                        if (w_last_k) begin
                            r_state <= r_is_dump ? S_IDLE : S_SEND;
                        end
                    end
                end
                S_SEND: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_status    <= r_found ? ST_OK : ST_NOT_FOUND;
                        r_index     <= r_found ? r_hit : '0;
                        r_data      <= r_found ? r_val : '0;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_index     = r_index;
    assign o_data      = r_data;
    assign o_last      = r_last;

    // count never passes the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count above capacity");

    // no word taken while the chain rotates
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("input taken while busy");

    // a clear empties the list
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_cmd == CMD_CLEAR)) |=> (r_count == '0))
        else $error("clear left entries");

    // every non-ok result is a single, final word
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != ST_OK)) |-> (r_last && (r_index == '0)))
        else $error("error result not final");

endmodule
